// ===== rtl/core/kf2_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kf2_pkg
// types, constants and the saturating helpers of the two-state filter
// ----------------------------------------------------------------------------
package kf2_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;
   localparam int ACC_BITS  = WORD_BITS + 4;
   localparam int PROD_BITS = 2 * WORD_BITS;

   localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic signed [WORD_BITS-1:0] FIX_ONE  = WORD_BITS'(1) <<< FRAC_BITS;
   localparam logic signed [WORD_BITS-1:0] COV_INIT = WORD_BITS'(100) <<< FRAC_BITS;

   localparam int NUM_REGS = 7;
   localparam logic [2:0] REG_TRANS_00   = 3'd0;
   localparam logic [2:0] REG_TRANS_01   = 3'd1;
   localparam logic [2:0] REG_TRANS_10   = 3'd2;
   localparam logic [2:0] REG_TRANS_11   = 3'd3;
   localparam logic [2:0] REG_OBS_0      = 3'd4;
   localparam logic [2:0] REG_OBS_1      = 3'd5;
   localparam logic [2:0] REG_MEAS_NOISE = 3'd6;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [ACC_BITS-1:0]  acc_type;

   typedef struct packed {
      logic signed [31:0] measurement;
      logic signed [31:0] ctrl_pos;
      logic signed [31:0] ctrl_vel;
   } req_type;

   typedef struct packed {
      logic signed [31:0] est_pos;
      logic signed [31:0] est_vel;
      logic signed [31:0] cov_00;
      logic signed [31:0] cov_01;
      logic signed [31:0] cov_10;
      logic signed [31:0] cov_11;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic     start;
      word_type num;
      word_type den;
   } div_req_type;

   function automatic word_type sat_acc(input acc_type v);
      word_type r;
      if (v > acc_type'(WORD_MAX)) r = WORD_MAX;
      else if (v < acc_type'(WORD_MIN)) r = WORD_MIN;
      else r = v[WORD_BITS-1:0];
      return r;
   endfunction

   function automatic word_type sat_neg(input word_type v);
      word_type r;
      if (v == WORD_MIN) r = WORD_MAX;
      else r = -v;
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kf2_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kf2_mul
// shared fixed-point multiplier: registered product, then round and saturate
// ----------------------------------------------------------------------------
module kf2_mul (
   input  wire                   clock,
   input  wire kf2_pkg::word_type a,
   input  wire kf2_pkg::word_type b,
   output kf2_pkg::word_type     prod
);
   import kf2_pkg::*;

   logic                 neg_ff;
   logic [PROD_BITS-1:0] mag_ff;
   logic [WORD_BITS-1:0] ma, mb;
   logic [PROD_BITS:0]   rnd;
   logic [PROD_BITS:0]   shf;
   logic [PROD_BITS:0]   lim;

   assign ma = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
   assign mb = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);

   always_ff @(posedge clock) begin
      mag_ff <= ma * mb;
      neg_ff <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
   end

   assign rnd = {1'b0, mag_ff} + ((PROD_BITS+1)'(1) << (FRAC_BITS - 1));
   assign shf = rnd >> FRAC_BITS;
   assign lim = neg_ff ? (PROD_BITS+1)'({1'b1, {(WORD_BITS-1){1'b0}}})
                       : (PROD_BITS+1)'({1'b0, {(WORD_BITS-1){1'b1}}});

   always_comb begin
      if (shf > lim) begin
         prod = neg_ff ? WORD_MIN : WORD_MAX;
      end else begin
         prod = neg_ff ? WORD_BITS'(-shf[WORD_BITS-1:0]) : shf[WORD_BITS-1:0];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/kf2_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kf2_div
// restoring divider, one quotient bit a cycle, num * 2^frac / den, rounded
// ----------------------------------------------------------------------------
module kf2_div (
   input  wire                      clock,
   input  wire                      reset,
   input  wire kf2_pkg::div_req_type req,
   output logic                     done,
   output kf2_pkg::word_type        quot
);
   import kf2_pkg::*;

   localparam int NUM_W = WORD_BITS + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                 busy_ff, busy_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [WORD_BITS:0]   rem_ff, rem_in;
   logic [WORD_BITS-1:0] den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [WORD_BITS:0]   trial;
   logic [NUM_W:0]       q_rnd;
   logic [NUM_W:0]       lim;
   logic [WORD_BITS+1:0] twice_rem;

   assign trial = {rem_ff[WORD_BITS-1:0], num_ff[NUM_W-1]};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         num_in  = {(req.num[WORD_BITS-1] ? WORD_BITS'(-req.num) : WORD_BITS'(req.num)),
                    {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = req.den;
         neg_in  = req.num[WORD_BITS-1];
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // quotient bits now sit in num_ff, remainder in rem_ff
   assign done      = busy_ff == 1'b0 && cnt_ff == '0;
   assign twice_rem = {rem_ff, 1'b0};
   assign q_rnd     = {1'b0, num_ff} +
                      ((twice_rem >= {2'b0, den_ff}) ? (NUM_W+1)'(1) : (NUM_W+1)'(0));
   assign lim = neg_ff ? (NUM_W+1)'({1'b1, {(WORD_BITS-1){1'b0}}})
                       : (NUM_W+1)'({1'b0, {(WORD_BITS-1){1'b1}}});

   always_comb begin
      if (q_rnd > lim) begin
         quot = neg_ff ? WORD_MIN : WORD_MAX;
      end else begin
         quot = neg_ff ? WORD_BITS'(-q_rnd[WORD_BITS-1:0]) : q_rnd[WORD_BITS-1:0];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/kalman_filter_2state_scalar_meas_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kalman_filter_2state_scalar_meas_top
// two-state kalman filter, scalar measurement, q16.16, saturating
// ----------------------------------------------------------------------------
// One item runs measurement update and prediction on a single shared
// multiplier (each product: operands in ST_MUL, registered result added in
// ST_WAIT) and a one-bit-a-cycle divider for the two gains. A sum passes
// ST_MUL and ST_WAIT once per product and then ST_ACC. When the update runs,
// the two divisions dominate. When the innovation variance is not positive,
// the update is skipped and only the prediction runs. The final step also
// waits while an earlier result has not been taken. req_ready is low from
// the accepted item until its result moves into the output register.
// Configuration writes are accepted at any time and act on the item in
// progress, so write them only between items.
// ----------------------------------------------------------------------------
module kalman_filter_2state_scalar_meas_top (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire kf2_pkg::req_type req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output kf2_pkg::rsp_type    rsp_data,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire [2:0]           csr_index,
   input  wire [31:0]          csr_data
);
   import kf2_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL  = 7'b0000010,
      ST_WAIT = 7'b0000100,
      ST_ACC  = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_DIVW = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   // sequencer steps: each sum is a list of products accumulated then saturated
   typedef enum logic [4:0] {
      SP_HP0, SP_HP1, SP_S, SP_HX, SP_T0, SP_T1, SP_K0, SP_K1,
      SP_M00, SP_M01, SP_M10, SP_M11, SP_P, SP_V,
      SP_NA, SP_NB, SP_NC, SP_ND,
      SP_XP, SP_XV, SP_F00, SP_F01, SP_F10, SP_F11,
      SP_CA, SP_CB, SP_CC, SP_CD
   } step_type;

   state_type st_ff, st_in;
   step_type  sp_ff, sp_in;
   logic      term_ff, term_in;

   word_type f00_ff, f01_ff, f10_ff, f11_ff, h0_ff, h1_ff, r_ff;
   word_type p_ff, v_ff, a_ff, b_ff, c_ff, d_ff;
   word_type z_ff, u0_ff, u1_ff;
   word_type hp0_ff, hp1_ff, s_ff, y_ff, t0_ff, t1_ff, k0_ff, k1_ff;
   word_type m00_ff, m01_ff, m10_ff, m11_ff;
   word_type na_ff, nb_ff, nc_ff, nd_ff;
   word_type f0_ff, f1_ff, f2_ff, f3_ff;
   word_type np_ff, nv_ff;
   acc_type  acc_ff, acc_in;
   logic     skip_ff;
   logic     rsp_valid_ff;
   rsp_type  rsp_ff;

   word_type    opa, opb, prod, res, quot;
   acc_type     bias;
   logic        div_done;
   div_req_type dreq;

   kf2_mul u_mul (.clock(clock), .a(opa), .b(opb), .prod(prod));
   kf2_div u_div (.clock(clock), .reset(reset), .req(dreq), .done(div_done), .quot(quot));

   // operand pairs for the one or two products of a step, plus the added constant
   always_comb begin
      opa  = '0;
      opb  = '0;
      bias = '0;
      case (sp_ff)
         SP_HP0: begin opa = term_ff ? h1_ff : h0_ff; opb = term_ff ? c_ff : a_ff; end
         SP_HP1: begin opa = term_ff ? h1_ff : h0_ff; opb = term_ff ? d_ff : b_ff; end
         SP_S: begin
            opa = term_ff ? hp1_ff : hp0_ff; opb = term_ff ? h1_ff : h0_ff;
            bias = acc_type'(r_ff);
         end
         SP_HX:  begin opa = term_ff ? h1_ff : h0_ff; opb = term_ff ? v_ff : p_ff; end
         SP_T0:  begin opa = term_ff ? b_ff : a_ff; opb = term_ff ? h1_ff : h0_ff; end
         SP_T1:  begin opa = term_ff ? d_ff : c_ff; opb = term_ff ? h1_ff : h0_ff; end
         SP_M00: begin opa = k0_ff; opb = h0_ff; end
         SP_M01: begin opa = k0_ff; opb = h1_ff; end
         SP_M10: begin opa = k1_ff; opb = h0_ff; end
         SP_M11: begin opa = k1_ff; opb = h1_ff; end
         SP_P:   begin opa = k0_ff; opb = y_ff; bias = acc_type'(p_ff); end
         SP_V:   begin opa = k1_ff; opb = y_ff; bias = acc_type'(v_ff); end
         SP_NA:  begin opa = term_ff ? m01_ff : m00_ff; opb = term_ff ? c_ff : a_ff; end
         SP_NB:  begin opa = term_ff ? m01_ff : m00_ff; opb = term_ff ? d_ff : b_ff; end
         SP_NC:  begin opa = term_ff ? m11_ff : m10_ff; opb = term_ff ? c_ff : a_ff; end
         SP_ND:  begin opa = term_ff ? m11_ff : m10_ff; opb = term_ff ? d_ff : b_ff; end
         SP_XP: begin
            opa = term_ff ? f01_ff : f00_ff; opb = term_ff ? v_ff : p_ff;
            bias = acc_type'(u0_ff);
         end
         SP_XV: begin
            opa = term_ff ? f11_ff : f10_ff; opb = term_ff ? v_ff : p_ff;
            bias = acc_type'(u1_ff);
         end
         SP_F00: begin opa = term_ff ? f01_ff : f00_ff; opb = term_ff ? c_ff : a_ff; end
         SP_F01: begin opa = term_ff ? f01_ff : f00_ff; opb = term_ff ? d_ff : b_ff; end
         SP_F10: begin opa = term_ff ? f11_ff : f10_ff; opb = term_ff ? c_ff : a_ff; end
         SP_F11: begin opa = term_ff ? f11_ff : f10_ff; opb = term_ff ? d_ff : b_ff; end
         SP_CA:  begin opa = term_ff ? f1_ff : f0_ff; opb = term_ff ? f01_ff : f00_ff; end
         SP_CB:  begin opa = term_ff ? f1_ff : f0_ff; opb = term_ff ? f11_ff : f10_ff; end
         SP_CC:  begin opa = term_ff ? f3_ff : f2_ff; opb = term_ff ? f01_ff : f00_ff; end
         SP_CD:  begin opa = term_ff ? f3_ff : f2_ff; opb = term_ff ? f11_ff : f10_ff; end
         default: begin end
      endcase
   end

   function automatic logic single_term(input step_type s);
      return s == SP_M00 || s == SP_M01 || s == SP_M10 || s == SP_M11 ||
             s == SP_P || s == SP_V;
   endfunction

   assign res = sat_acc(acc_ff);

   assign dreq.start = st_ff == ST_DIV;
   assign dreq.num   = (sp_ff == SP_K0) ? t0_ff : t1_ff;
   assign dreq.den   = s_ff;

   always_comb begin
      st_in   = st_ff;
      sp_in   = sp_ff;
      term_in = term_ff;
      acc_in  = acc_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_valid) begin
               st_in = ST_MUL; sp_in = SP_HP0; term_in = 1'b0;
            end
         end
         ST_MUL: begin
            st_in = ST_WAIT;
            if (!term_ff) acc_in = bias;
         end
         ST_WAIT: begin
            acc_in = acc_ff + acc_type'(prod);
            if (term_ff || single_term(sp_ff)) begin
               st_in = ST_ACC;
            end else begin
               term_in = 1'b1; st_in = ST_MUL;
            end
         end
         ST_ACC: begin
            term_in = 1'b0;
            st_in   = ST_MUL;
            case (sp_ff)
               SP_S: begin
                  if (res > 0) sp_in = SP_HX;
                  else sp_in = SP_XP;
               end
               SP_T1: begin sp_in = SP_K0; st_in = ST_DIV; end
               SP_CD: st_in = ST_OUT;
               default: sp_in = step_type'(sp_ff + 5'd1);
            endcase
         end
         ST_DIV: st_in = ST_DIVW;
         ST_DIVW: begin
            if (div_done) begin
               if (sp_ff == SP_K0) begin
                  sp_in = SP_K1; st_in = ST_DIV;
               end else begin
                  sp_in = SP_M00; st_in = ST_MUL; term_in = 1'b0;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         sp_ff        <= SP_HP0;
         term_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         f00_ff <= FIX_ONE; f01_ff <= FIX_ONE; f10_ff <= '0; f11_ff <= FIX_ONE;
         h0_ff  <= FIX_ONE; h1_ff  <= '0;      r_ff   <= FIX_ONE;
         p_ff <= '0; v_ff <= '0; a_ff <= COV_INIT; b_ff <= '0; c_ff <= '0;
         d_ff <= COV_INIT;
      end else begin
         st_ff   <= st_in;
         sp_ff   <= sp_in;
         term_ff <= term_in;
         if (csr_valid) begin
            case (csr_index)
               REG_TRANS_00:   f00_ff <= csr_data;
               REG_TRANS_01:   f01_ff <= csr_data;
               REG_TRANS_10:   f10_ff <= csr_data;
               REG_TRANS_11:   f11_ff <= csr_data;
               REG_OBS_0:      h0_ff  <= csr_data;
               REG_OBS_1:      h1_ff  <= csr_data;
               REG_MEAS_NOISE: r_ff   <= {1'b0, csr_data[30:0]};
               default: begin end
            endcase
         end
         if (st_ff == ST_ACC) begin
            case (sp_ff)
               SP_P:  p_ff <= res;
               SP_V:  v_ff <= res;
               SP_ND: begin a_ff <= na_ff; b_ff <= nb_ff; c_ff <= nc_ff; d_ff <= res; end
               SP_CA: a_ff <= res;
               SP_CB: b_ff <= res;
               SP_CC: c_ff <= res;
               SP_CD: begin d_ff <= res; p_ff <= np_ff; v_ff <= nv_ff; end
               default: begin end
            endcase
         end
         if (st_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      acc_ff <= acc_in;
      if (st_ff == ST_IDLE && req_valid) begin
         z_ff  <= req_data.measurement;
         u0_ff <= req_data.ctrl_pos;
         u1_ff <= req_data.ctrl_vel;
      end
      if (st_ff == ST_ACC) begin
         case (sp_ff)
            SP_HP0: hp0_ff <= res;
            SP_HP1: hp1_ff <= res;
            SP_S:   begin s_ff <= res; skip_ff <= !(res > 0); end
            SP_HX:  y_ff  <= sat_acc(acc_type'(z_ff) - acc_type'(res));
            SP_T0:  t0_ff <= res;
            SP_T1:  t1_ff <= res;
            SP_M00: m00_ff <= sat_acc(acc_type'(FIX_ONE) - acc_type'(res));
            SP_M01: m01_ff <= sat_neg(res);
            SP_M10: m10_ff <= sat_neg(res);
            SP_M11: m11_ff <= sat_acc(acc_type'(FIX_ONE) - acc_type'(res));
            SP_NA:  na_ff <= res;
            SP_NB:  nb_ff <= res;
            SP_NC:  nc_ff <= res;
            SP_XP:  np_ff <= res;
            SP_XV:  nv_ff <= res;
            SP_F00: f0_ff <= res;
            SP_F01: f1_ff <= res;
            SP_F10: f2_ff <= res;
            SP_F11: f3_ff <= res;
            default: begin end
         endcase
      end
      if (st_ff == ST_DIVW && div_done) begin
         if (sp_ff == SP_K0) k0_ff <= quot;
         else k1_ff <= quot;
      end
      if (st_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff.est_pos <= p_ff;
         rsp_ff.est_vel <= v_ff;
         rsp_ff.cov_00  <= a_ff;
         rsp_ff.cov_01  <= b_ff;
         rsp_ff.cov_10  <= c_ff;
         rsp_ff.cov_11  <= d_ff;
         rsp_ff.status  <= skip_ff;
      end
   end

   assign req_ready = st_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while busy");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped");

   a_div_gate: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DIV) |-> (s_ff > 0))
      else $error("division with nonpositive variance");
endmodule
`default_nettype wire
